@@ src/xsh_pkg.sv @@
// ----------------------------------------------------------------------------
// xsh_pkg
// Shared types and constants of the xoshiro256** generator with SplitMix64
// seeding.
// ----------------------------------------------------------------------------
package xsh_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int NUM_WORDS = 4;
    localparam int WIDX_W    = $clog2(NUM_WORDS);

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

    localparam int SHIFT_UPD = 17;
    localparam int ROT_UPD   = 45;
    localparam int ROT_OUT   = 7;
    localparam int MIX_SH0   = 30;
    localparam int MIX_SH1   = 27;
    localparam int MIX_SH2   = 31;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word p;
    } t_mul_rsp;

    function automatic t_word rotl(input t_word v, input int amt);
        rotl = (v << amt) | (v >> (WORD_W - amt));
    endfunction

endpackage

@@ src/xsh_mul.sv @@
// ----------------------------------------------------------------------------
// xsh_mul
// Iterative 64 x 64 multiplier returning the low 64 bits of the product.
// One 32 x 32 multiplier forms the three needed partial products in turn;
// the result is presented together with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module xsh_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xsh_pkg::t_mul_req i_req,
    output xsh_pkg::t_mul_rsp o_rsp
);
    import xsh_pkg::*;

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_HL = 2'd1;
    localparam logic [1:0] STEP_LH = 2'd2;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    t_word             r_a;
    t_word             r_b;
    t_word             r_p0;
    logic [HALF_W-1:0] r_x;
    logic [HALF_W-1:0] r_y;
    logic [HALF_W-1:0] w_opx;
    logic [HALF_W-1:0] w_opy;
    t_word             w_prod;

    always_comb begin
        case (r_step)
            STEP_LL: begin
                w_opx = r_a[HALF_W-1:0];
                w_opy = r_b[HALF_W-1:0];
            end
            STEP_HL: begin
                w_opx = r_a[WORD_W-1:HALF_W];
                w_opy = r_b[HALF_W-1:0];
            end
            default: begin
                w_opx = r_a[HALF_W-1:0];
                w_opy = r_b[WORD_W-1:HALF_W];
            end
        endcase
    end

    assign w_prod = WORD_W'(w_opx) * WORD_W'(w_opy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LL;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_LH) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            case (r_step)
                STEP_LL: r_p0 <= w_prod;
                STEP_HL: r_x  <= w_prod[HALF_W-1:0];
                default: r_y  <= w_prod[HALF_W-1:0];
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = {r_p0[WORD_W-1:HALF_W] + r_x + r_y, r_p0[HALF_W-1:0]};

endmodule

@@ src/xoshiro256_prng_with_seeding_core.sv @@
// Next request: the result is registered in r_tmp (state NXT), then in
// r_out_data (state NXT2, held while the last output word is untaken);
// no new request is taken until the core is back in IDLE. Seed request:
// four SplitMix64 rounds, each an add and two passes through the shared
// multiplier. Reset is synchronous; afterwards the core expands seed zero
// before it accepts its first request.
// ----------------------------------------------------------------------------
// xoshiro256_prng_with_seeding_core
// xoshiro256** generator with 256 bits of state and SplitMix64 seeding.
// ----------------------------------------------------------------------------
module xoshiro256_prng_with_seeding_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // seed_value[63:0]
    input  logic        i_s_tuser,   // req_type[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // random_word[63:0]
);
    import xsh_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_NXT       = 7'b0000010,
        ST_NXT2      = 7'b0000100,
        ST_ADD       = 7'b0001000,
        ST_MULA_GO   = 7'b0010000,
        ST_MULA_WAIT = 7'b0100000,
        ST_MULB_WAIT = 7'b1000000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_word             r_s [NUM_WORDS];
    t_word             r_acc;
    t_word             r_tmp;
    logic [WIDX_W-1:0] r_widx;
    logic              r_out_valid;
    t_word             r_out_data;
    t_mul_req          w_mul_req;
    t_mul_rsp          w_mul_rsp;
    logic              w_accept;
    logic              w_load_out;
    t_word             w_mix_b;
    t_word             w_mix_out;

    xsh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load_out = (r_state == ST_NXT2) && (!r_out_valid || i_m_tready);
    assign w_mix_b    = w_mul_rsp.p ^ (w_mul_rsp.p >> MIX_SH1);
    assign w_mix_out  = w_mul_rsp.p ^ (w_mul_rsp.p >> MIX_SH2);

    always_comb begin
        w_mul_req.start = (r_state == ST_MULA_GO) ||
                          ((r_state == ST_MULA_WAIT) && w_mul_rsp.done);
        if (r_state == ST_MULA_GO) begin
            w_mul_req.a = r_acc ^ (r_acc >> MIX_SH0);
            w_mul_req.b = MIX_MUL_A;
        end else begin
            w_mul_req.a = w_mix_b;
            w_mul_req.b = MIX_MUL_B;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_s_tuser ? ST_ADD : ST_NXT;
                end
            end
            ST_NXT:     n_state = ST_NXT2;
            ST_NXT2: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADD:     n_state = ST_MULA_GO;
            ST_MULA_GO: n_state = ST_MULA_WAIT;
            ST_MULA_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = ST_MULB_WAIT;
                end
            end
            ST_MULB_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = (r_widx == LAST_WORD) ? ST_IDLE : ST_ADD;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ADD;
            r_acc       <= '0;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_acc  <= i_s_tdata;
                r_widx <= '0;
            end else if (r_state == ST_ADD) begin
                r_acc <= r_acc + GOLDEN_STEP;
            end else if ((r_state == ST_MULB_WAIT) && w_mul_rsp.done) begin
                r_widx <= r_widx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_NXT) begin
            r_tmp <= rotl(r_s[1] + (r_s[1] << 2), ROT_OUT);
        end
        if (w_load_out) begin
            r_out_data <= r_tmp + (r_tmp << 3);
            r_s[0] <= r_s[0] ^ r_s[3] ^ r_s[1];
            r_s[1] <= r_s[1] ^ r_s[2] ^ r_s[0];
            r_s[2] <= r_s[2] ^ r_s[0] ^ (r_s[1] << SHIFT_UPD);
            r_s[3] <= rotl(r_s[3] ^ r_s[1], ROT_UPD);
        end else if ((r_state == ST_MULB_WAIT) && w_mul_rsp.done) begin
            r_s[r_widx] <= w_mix_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("core still ready after taking a request");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == ST_MULA_WAIT || r_state == ST_MULB_WAIT))
        else $error("multiplier finished outside a seeding wait state");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NXT2 && r_out_valid && !i_m_tready) |=> r_state == ST_NXT2)
        else $error("next result left its state while the output was full");

    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MULA_GO) |=> !w_mul_rsp.done)
        else $error("multiplier done too early after start");

endmodule

@@ dv/xoshiro256_prng_with_seeding_core_tb.sv @@
// ----------------------------------------------------------------------------
// xoshiro256_prng_with_seeding_core_tb
// Self-checking bench for the xoshiro256** core: a short directed sequence of
// seed and next requests, then a long random mix. Random idle cycles are put
// on both stream sides, with one long stretch free of them. Every output word
// is compared with a bit-exact software copy of the generator state.
// ----------------------------------------------------------------------------
class prng_scoreboard;
    xsh_pkg::t_word gen_words[xsh_pkg::NUM_WORDS];
    xsh_pkg::t_word expected_words[$];
    int             mismatches;

    function new();
        mismatches = 0;
        expand_seed('0);
    endfunction

    function void expand_seed(input xsh_pkg::t_word base);
        xsh_pkg::t_word acc;
        xsh_pkg::t_word mix;
        acc = base;
        for (int w = 0; w < xsh_pkg::NUM_WORDS; w++) begin
            acc = acc + xsh_pkg::GOLDEN_STEP;
            mix = acc;
            mix = (mix ^ (mix >> xsh_pkg::MIX_SH0)) * xsh_pkg::MIX_MUL_A;
            mix = (mix ^ (mix >> xsh_pkg::MIX_SH1)) * xsh_pkg::MIX_MUL_B;
            gen_words[w] = mix ^ (mix >> xsh_pkg::MIX_SH2);
        end
    endfunction

    function xsh_pkg::t_word advance_state();
        xsh_pkg::t_word scaled;
        xsh_pkg::t_word rotated;
        xsh_pkg::t_word shifted;
        scaled  = gen_words[1] * 64'd5;
        rotated = {scaled[56:0], scaled[63:57]};
        shifted = gen_words[1] << xsh_pkg::SHIFT_UPD;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ shifted;
        gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
        return rotated * 64'd9;
    endfunction

    function void note_request(input logic reseed, input xsh_pkg::t_word seed);
        if (reseed) begin
            expand_seed(seed);
        end else begin
            expected_words.push_back(advance_state());
        end
    endfunction

    function void check_word(input xsh_pkg::t_word got);
        xsh_pkg::t_word want;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected random word %h with no request pending", got);
            end
        end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Random word mismatch: expected %h, got %h", want, got);
                end
            end
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module xoshiro256_prng_with_seeding_core_tb;
    import xsh_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1300;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // seed_value[63:0]
    logic        i_s_tuser  = 1'b0; // req_type[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;         // random_word[63:0]

    logic           no_gaps = 1'b0;
    int             cycles  = 0;
    prng_scoreboard sb      = new();

    xoshiro256_prng_with_seeding_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= no_gaps || ($urandom_range(0, 99) >= 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_request(i_s_tuser, i_s_tdata);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_word(o_m_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic reseed, input t_word seed);
        while (!no_gaps && $urandom_range(0, 99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= reseed;
        i_s_tdata  <= seed;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_word seed;
        int    pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(1'b0, '0);
        send_request(1'b0, '1);
        send_request(1'b1, '0);
        send_request(1'b0, '0);
        send_request(1'b0, '0);
        send_request(1'b1, '1);
        send_request(1'b0, '0);
        send_request(1'b1, 64'd1);
        send_request(1'b0, 64'h5555_5555_5555_5555);
        send_request(1'b1, 64'h8000_0000_0000_0000);
        send_request(1'b0, '0);
        send_request(1'b1, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(1'b0, '1);
        send_request(1'b1, 64'h5555_5555_5555_5555);
        send_request(1'b0, {$urandom, $urandom});
        send_request(1'b1, 64'h7fff_ffff_ffff_ffff);
        send_request(1'b1, {$urandom, $urandom});
        send_request(1'b0, '0);
        send_request(1'b0, '0);
        send_request(1'b1, 64'h0123_4567_89ab_cdef);
        send_request(1'b1, 64'hfedc_ba98_7654_3210);
        send_request(1'b0, '0);
        send_request(1'b0, {$urandom, $urandom});

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps <= (n >= 500 && n < 700);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                seed = ($urandom_range(0, 1) != 0) ? '1 : '0;
            end else begin
                seed = {$urandom, $urandom};
            end
            send_request(pick < 13, seed);
        end
        i_s_tvalid <= 1'b0;
        no_gaps    <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
